/* design/mvfd_pkg.sv */
// ----------------------------------------------------------------------------
// Mirrored VFD clock driver package
// Shared types, codes, segment table and digit helpers for the display driver.
// ----------------------------------------------------------------------------
package mvfd_pkg;

    // Width of the colon timer; must be at least the colon register width.
    localparam int ELAPSED_W   = 10;
    localparam int NUM_GRIDS   = 5;
    localparam int GRID_IDX_W  = 3;
    localparam int CODE_W      = 5;
    localparam int SEG_W       = 9;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 3;

    typedef logic [CODE_W-1:0] code_t;

    localparam code_t CODE_BLANK = 5'd18;
    localparam code_t CODE_COLON = 5'd19;

    // Position of the colon digit.
    localparam logic [GRID_IDX_W-1:0] COLON_POS = 3'd2;
    localparam logic [GRID_IDX_W-1:0] LAST_GRID = 3'd4;

    localparam logic [SEG_W-1:0] SEG_B   = 9'h002;
    localparam logic [SEG_W-1:0] SEG_C   = 9'h004;
    localparam logic [SEG_W-1:0] SEG_E   = 9'h010;
    localparam logic [SEG_W-1:0] SEG_F   = 9'h020;
    localparam logic [SEG_W-1:0] SEG_ALL = 9'h1FF;

    typedef enum logic [1:0] {
        MODE_SECOND = 2'd0,
        MODE_MUX    = 2'd1,
        MODE_MS     = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ON_HOUR     = 3'd0,
        REG_ON_MINUTE   = 3'd1,
        REG_OFF_HOUR    = 3'd2,
        REG_OFF_MINUTE  = 3'd3,
        REG_COLON_TICKS = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [4:0] on_hour;
        logic [5:0] on_minute;
        logic [4:0] off_hour;
        logic [5:0] off_minute;
        logic [9:0] colon_ticks;
    } cfg_t;

    // Digit state handed from the time keeper to the grid scanner.
    typedef struct packed {
        logic [NUM_GRIDS-1:0][CODE_W-1:0] digits;
        logic                             colon_lit;
    } disp_status_t;

    // Lit segments for each digit code; unused codes are dark.
    function automatic logic [SEG_W-1:0] seg_decode(input code_t code);
        logic [SEG_W-1:0] s;
        case (code)
            5'd0:    s = 9'h03F;
            5'd1:    s = 9'h006;
            5'd2:    s = 9'h05B;
            5'd3:    s = 9'h04F;
            5'd4:    s = 9'h066;
            5'd5:    s = 9'h06D;
            5'd6:    s = 9'h07D;
            5'd7:    s = 9'h007;
            5'd8:    s = 9'h07F;
            5'd9:    s = 9'h06F;
            5'd10:   s = 9'h077;
            5'd11:   s = 9'h07C;
            5'd12:   s = 9'h039;
            5'd13:   s = 9'h05E;
            5'd14:   s = 9'h079;
            5'd15:   s = 9'h071;
            5'd16:   s = 9'h008;
            5'd17:   s = 9'h040;
            5'd18:   s = 9'h000;
            5'd19:   s = 9'h180;
            default: s = 9'h000;
        endcase
        return s;
    endfunction

    // The display is viewed in a mirror: B trades with F and C with E.
    function automatic logic [SEG_W-1:0] mirror_segments(input logic [SEG_W-1:0] d);
        logic [SEG_W-1:0] m;
        m = d & ~(SEG_B | SEG_C | SEG_E | SEG_F);
        if ((d & SEG_B) != '0) m = m | SEG_F;
        if ((d & SEG_C) != '0) m = m | SEG_E;
        if ((d & SEG_E) != '0) m = m | SEG_C;
        if ((d & SEG_F) != '0) m = m | SEG_B;
        return m;
    endfunction

    // Tens digit of a 6-bit value by reciprocal multiply (205/2048).
    function automatic logic [2:0] tens_of(input logic [5:0] x);
        logic [13:0] prod;
        prod = 14'(x) * 14'd205;
        return prod[13:11];
    endfunction

    // Units digit of a 6-bit value.
    function automatic logic [3:0] units_of(input logic [5:0] x);
        logic [5:0] tens_x10;
        logic [5:0] rem;
        tens_x10 = 6'(tens_of(x)) * 6'd10;
        rem      = x - tens_x10;
        return rem[3:0];
    endfunction

endpackage

/* design/mvfd_time.sv */
// ----------------------------------------------------------------------------
// Mirrored VFD time keeper
// Holds the hour/minute digits, the filament schedule state and the colon timer.
// ----------------------------------------------------------------------------
module mvfd_time (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  mvfd_pkg::mode_t       mode,
    input  logic [4:0]            hours,
    input  logic [5:0]            minutes,
    input  mvfd_pkg::cfg_t        cfg,
    output mvfd_pkg::disp_status_t status,
    output logic                  filament_next
);
    import mvfd_pkg::*;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    code_t                digit_reg [NUM_GRIDS];
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic                 filament_reg;
    logic                 sched_enabled;
    logic                 on_match;
    logic                 off_match;

    // Filament schedule: off wins over on; equal times disable the schedule.
    always_comb
    begin
        sched_enabled = !((cfg.on_hour == cfg.off_hour) && (cfg.on_minute == cfg.off_minute));
        on_match      = (hours == cfg.on_hour) && (minutes == cfg.on_minute);
        off_match     = (hours == cfg.off_hour) && (minutes == cfg.off_minute);
        filament_next = filament_reg;
        if (fire && (mode == MODE_SECOND) && sched_enabled)
        begin
            if (off_match)
                filament_next = 1'b0;
            else if (on_match)
                filament_next = 1'b1;
        end
    end

    // Colon timer restarts on a second event and counts millisecond ticks, saturating at its maximum.
    always_comb
    begin
        elapsed_next = elapsed_reg;
        if (fire)
        begin
            case (mode)
                MODE_SECOND: elapsed_next = '0;
                MODE_MS:
                begin
                    if (elapsed_reg != ELAPSED_MAX)
                        elapsed_next = elapsed_reg + 1'b1;
                end
                default: elapsed_next = elapsed_reg;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg[0] <= 5'd2;
            digit_reg[1] <= 5'd3;
            digit_reg[2] <= CODE_COLON;
            digit_reg[3] <= 5'd4;
            digit_reg[4] <= 5'd5;
            elapsed_reg  <= '0;
            filament_reg <= 1'b1;
        end
        else
        begin
            elapsed_reg  <= elapsed_next;
            filament_reg <= filament_next;
            if (fire && (mode == MODE_SECOND))
            begin
                digit_reg[0] <= code_t'(tens_of(6'(hours)));
                digit_reg[1] <= code_t'(units_of(6'(hours)));
                digit_reg[3] <= code_t'(tens_of(minutes));
                digit_reg[4] <= code_t'(units_of(minutes));
            end
        end
    end

    // The colon digit is taken from the timer, so its stored code is not read.
    always_comb
    begin
        for (int i = 0; i < NUM_GRIDS; i++)
            status.digits[i] = digit_reg[i];
        status.colon_lit = !(elapsed_reg > ELAPSED_W'(cfg.colon_ticks));
    end

endmodule

/* design/mvfd_scan.sv */
// ----------------------------------------------------------------------------
// Mirrored VFD grid scanner
// Steps the active grid and builds the grid and segment drive for it.
// ----------------------------------------------------------------------------
module mvfd_scan (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 fire,
    input  mvfd_pkg::mode_t                      mode,
    input  mvfd_pkg::disp_status_t               status,
    output logic [mvfd_pkg::NUM_GRIDS-1:0]       grid_next,
    output logic [mvfd_pkg::SEG_W-1:0]           seg_next
);
    import mvfd_pkg::*;

    logic [GRID_IDX_W-1:0] grid_idx_reg;
    logic [GRID_IDX_W-1:0] grid_idx_next;
    logic [GRID_IDX_W-1:0] src_pos;
    logic [NUM_GRIDS-1:0]  grid_reg;
    logic [SEG_W-1:0]      seg_reg;
    code_t                 src_code;
    logic [SEG_W-1:0]      lit;
    logic                  step;

    // Next grid, mirrored digit position and its segment pattern.
    always_comb
    begin
        step          = fire && (mode == MODE_MUX);
        grid_idx_next = (grid_idx_reg >= LAST_GRID) ? '0 : grid_idx_reg + 1'b1;
        src_pos       = LAST_GRID - grid_idx_next;
        if (src_pos == COLON_POS)
            src_code = status.colon_lit ? CODE_COLON : CODE_BLANK;
        else
            src_code = status.digits[src_pos];
        lit = mirror_segments(seg_decode(src_code));
        if (step)
        begin
            grid_next = ~(NUM_GRIDS'(1) << grid_idx_next);
            seg_next  = SEG_ALL & ~lit;
        end
        else
        begin
            grid_next = grid_reg;
            seg_next  = seg_reg;
        end
    end

    // Held drive lines and grid pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_idx_reg <= '0;
            grid_reg     <= '0;
            seg_reg      <= '0;
        end
        else
        begin
            if (step)
                grid_idx_reg <= grid_idx_next;
            grid_reg <= grid_next;
            seg_reg  <= seg_next;
        end
    end

endmodule

/* design/mirrored_vfd_clock_mux_driver.sv */
// ----------------------------------------------------------------------------
// Mirrored VFD clock multiplex driver
// Top level: input register, time keeper, grid scanner and result register.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the in_valid/in_ready channel with mode, hours and minutes.
// A second event loads the time digits, applies the filament schedule and
// restarts the colon timer; a millisecond tick advances the timer; a multiplex
// tick steps to the next grid and drives its mirrored digit.
// Every item yields exactly one transfer on out_valid/out_ready carrying
// grid_lines, segment_lines and filament_enable.
// An accepted item is registered in the input register, then in the result
// register once that register is free or its result is being taken.
// Throughput is one item per cycle while the receiver is ready; while a
// result waits, the input register can still take one more item.
// When the receiver stalls, the result register holds and in_ready drops once
// the input register is also full.
// Reset clears both stages, sets the digits to 23:45 with the colon lit, the
// filament on, the colon window to 500 ms and the schedule times to zero.
// The user writes registers through cfg_we/cfg_index/cfg_data only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module mirrored_vfd_clock_mux_driver (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic [4:0]                          hours,
    input  logic [5:0]                          minutes,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [4:0]                          grid_lines,
    output logic [8:0]                          segment_lines,
    output logic                                filament_enable,
    input  logic                                cfg_we,
    input  logic [mvfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mvfd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mvfd_pkg::*;

    cfg_t                 cfg_reg;
    logic                 s1_valid_reg;
    mode_t                s1_mode_reg;
    logic [4:0]           s1_hours_reg;
    logic [5:0]           s1_minutes_reg;
    logic                 s1_advance;
    logic                 fire;
    logic                 out_valid_reg;
    logic [NUM_GRIDS-1:0] grid_out_reg;
    logic [SEG_W-1:0]     seg_out_reg;
    logic                 fil_out_reg;
    disp_status_t         status;
    logic                 filament_next;
    logic [NUM_GRIDS-1:0] grid_next;
    logic [SEG_W-1:0]     seg_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_hour     <= '0;
            cfg_reg.on_minute   <= '0;
            cfg_reg.off_hour    <= '0;
            cfg_reg.off_minute  <= '0;
            cfg_reg.colon_ticks <= 10'd500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ON_HOUR:     cfg_reg.on_hour     <= cfg_data[4:0];
                REG_ON_MINUTE:   cfg_reg.on_minute   <= cfg_data[5:0];
                REG_OFF_HOUR:    cfg_reg.off_hour    <= cfg_data[4:0];
                REG_OFF_MINUTE:  cfg_reg.off_minute  <= cfg_data[5:0];
                REG_COLON_TICKS: cfg_reg.colon_ticks <= cfg_data[9:0];
                default:         ;
            endcase
        end
    end

    // Handshake: the input stage moves on whenever the result register is free or its result is being taken.
    assign s1_advance = !out_valid_reg || out_ready;
    assign fire       = s1_valid_reg && s1_advance;
    assign in_ready   = !s1_valid_reg || s1_advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_mode_reg    <= mode_t'(mode);
            s1_hours_reg   <= hours;
            s1_minutes_reg <= minutes;
        end
    end

    // Time keeping and grid scanning.
    mvfd_time u_time (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .mode          (s1_mode_reg),
        .hours         (s1_hours_reg),
        .minutes       (s1_minutes_reg),
        .cfg           (cfg_reg),
        .status        (status),
        .filament_next (filament_next)
    );

    mvfd_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .mode      (s1_mode_reg),
        .status    (status),
        .grid_next (grid_next),
        .seg_next  (seg_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            grid_out_reg <= grid_next;
            seg_out_reg  <= seg_next;
            fil_out_reg  <= filament_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign grid_lines      = grid_out_reg;
    assign segment_lines   = seg_out_reg;
    assign filament_enable = fil_out_reg;

    // A held item in the input stage is never dropped.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg)
        else $error("input stage lost an item while stalled");

    // A taken result with no new item behind it leaves the output empty.
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && !s1_valid_reg) |=> !out_valid_reg)
        else $error("result repeated after transfer");

    // A full input stage only admits a new item when it is moving on itself.
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && s1_valid_reg) |-> fire)
        else $error("input accepted over an unfinished item");

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Mirrored VFD clock multiplex driver testbench
// Drives second events, multiplex ticks and millisecond ticks through the
// valid/ready input, predicts the grid, segment and filament lines of every
// item with a cycle-free model of the display, and checks each output
// transfer against the oldest prediction. Directed checks cover reset state,
// field extremes, the filament schedule, the colon window and timer
// saturation. Back-pressure and random phases under several register
// settings follow.
// ----------------------------------------------------------------------------
module tb;
    import mvfd_pkg::*;

    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_ITEMS    = 100;

    typedef struct packed {
        logic [4:0] grid;
        logic [8:0] seg;
        logic       fil;
    } lines_t;

    // Block ports; the inputs are driven to known values from time zero.
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [1:0]             mode      = MODE_NONE;
    logic [4:0]             hours     = '0;
    logic [5:0]             minutes   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [4:0]             grid_lines;
    logic [8:0]             segment_lines;
    logic                   filament_enable;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Display model state and its copy of the registers.
    logic [4:0]            sched_on_hour;
    logic [5:0]            sched_on_minute;
    logic [4:0]            sched_off_hour;
    logic [5:0]            sched_off_minute;
    logic [9:0]            colon_window;
    code_t                 shown_digit [NUM_GRIDS];
    logic [GRID_IDX_W-1:0] scan_grid;
    logic [ELAPSED_W-1:0]  ms_since_second;
    logic                  filament_running;
    logic [4:0]            held_grid;
    logic [8:0]            held_seg;

    lines_t pending_lines[$];
    int     errors       = 0;
    bit     idle_on      = 1'b1;
    bit     hold_req     = 1'b0;
    int     stall_left   = 0;
    int     quiet_cycles = 0;

    mirrored_vfd_clock_mux_driver DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .hours           (hours),
        .minutes         (minutes),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .grid_lines      (grid_lines),
        .segment_lines   (segment_lines),
        .filament_enable (filament_enable),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Free-running clock, period 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Lit segments of each digit code, bit 0 is segment A.
    function automatic logic [8:0] glyph_of(input code_t code);
        case (code)
            5'd0:    return 9'h03F;
            5'd1:    return 9'h006;
            5'd2:    return 9'h05B;
            5'd3:    return 9'h04F;
            5'd4:    return 9'h066;
            5'd5:    return 9'h06D;
            5'd6:    return 9'h07D;
            5'd7:    return 9'h007;
            5'd8:    return 9'h07F;
            5'd9:    return 9'h06F;
            5'd10:   return 9'h077;
            5'd11:   return 9'h07C;
            5'd12:   return 9'h039;
            5'd13:   return 9'h05E;
            5'd14:   return 9'h079;
            5'd15:   return 9'h071;
            5'd16:   return 9'h008;
            5'd17:   return 9'h040;
            5'd19:   return 9'h180;
            default: return 9'h000;
        endcase
    endfunction

    // Seen in the mirror, B and F change places, and so do C and E.
    function automatic logic [8:0] mirror_view(input logic [8:0] d);
        return {d[8:6], d[1], d[2], d[3], d[4], d[5], d[0]};
    endfunction

    // Display state right after reset.
    task automatic reset_display_model();
        sched_on_hour    = '0;
        sched_on_minute  = '0;
        sched_off_hour   = '0;
        sched_off_minute = '0;
        colon_window     = 10'd500;
        shown_digit[0]   = 5'd2;
        shown_digit[1]   = 5'd3;
        shown_digit[2]   = CODE_COLON;
        shown_digit[3]   = 5'd4;
        shown_digit[4]   = 5'd5;
        scan_grid        = '0;
        ms_since_second  = '0;
        filament_running = 1'b1;
        held_grid        = '0;
        held_seg         = '0;
    endtask

    // Apply one accepted item to the display model and queue its lines.
    task automatic predict_lines(input mode_t m, input logic [4:0] h, input logic [5:0] mi);
        logic [8:0] lit;
        if (m == MODE_SECOND)
        begin
            ms_since_second = '0;
            shown_digit[4]  = code_t'(mi % 10);
            shown_digit[3]  = code_t'(mi / 10);
            shown_digit[1]  = code_t'(h % 10);
            shown_digit[0]  = code_t'(h / 10);
            // Equal on and off times disable the schedule; off wins a tie.
            if (!(sched_on_hour == sched_off_hour && sched_on_minute == sched_off_minute))
            begin
                if (h == sched_on_hour && mi == sched_on_minute)
                    filament_running = 1'b1;
                if (h == sched_off_hour && mi == sched_off_minute)
                    filament_running = 1'b0;
            end
        end
        else if (m == MODE_MS)
        begin
            if (ms_since_second != '1)
                ms_since_second = ms_since_second + 1'b1;
        end

        // The colon digit is refreshed after every item.
        shown_digit[COLON_POS] = (ms_since_second > colon_window) ? CODE_BLANK : CODE_COLON;

        if (m == MODE_MUX)
        begin
            scan_grid = (scan_grid >= LAST_GRID) ? '0 : scan_grid + 1'b1;
            lit       = mirror_view(glyph_of(shown_digit[LAST_GRID - scan_grid]));
            held_grid = ~(5'b00001 << scan_grid);
            held_seg  = ~lit;
        end

        pending_lines.push_back('{grid: held_grid, seg: held_seg, fil: filament_running});
    endtask

    // Offer one item and hold it until the transfer happens.
    task automatic send_item(input mode_t m, input logic [4:0] h, input logic [5:0] mi);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        hours    <= h;
        minutes  <= mi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_lines(m, h, mi);
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_lines.size() != 0);
    endtask

    // One register write; the caller lowers the write enable afterwards.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_ON_HOUR:     sched_on_hour    = val[4:0];
            REG_ON_MINUTE:   sched_on_minute  = val[5:0];
            REG_OFF_HOUR:    sched_off_hour   = val[4:0];
            REG_OFF_MINUTE:  sched_off_minute = val[5:0];
            REG_COLON_TICKS: colon_window     = val[9:0];
            default: ;
        endcase
    endtask

    // Reprogram every register once the block has gone idle.
    task automatic load_config(input logic [4:0] on_h, input logic [5:0] on_m,
                               input logic [4:0] off_h, input logic [5:0] off_m,
                               input logic [9:0] ticks);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_ON_HOUR, CFG_DATA_W'(on_h));
        write_reg(REG_ON_MINUTE, CFG_DATA_W'(on_m));
        write_reg(REG_OFF_HOUR, CFG_DATA_W'(off_h));
        write_reg(REG_OFF_MINUTE, CFG_DATA_W'(off_m));
        write_reg(REG_COLON_TICKS, CFG_DATA_W'(ticks));
        cfg_we <= 1'b0;
    endtask

    // Send multiplex ticks until the colon grid is the one being driven.
    task automatic show_colon_digit();
        do
            send_item(MODE_MUX, 5'($urandom), 6'($urandom));
        while (scan_grid != COLON_POS);
    endtask

    // Random item: mostly ticks, with second events that often hit the schedule.
    task automatic send_random_item();
        int         pick;
        logic [4:0] h;
        logic [5:0] mi;
        pick = $urandom_range(0, 99);
        h    = 5'($urandom_range(0, 23));
        mi   = 6'($urandom_range(0, 59));
        if ($urandom_range(0, 9) == 0)
        begin
            h  = 5'($urandom);
            mi = 6'($urandom);
        end
        if (pick < 6)
            send_item(MODE_SECOND, sched_on_hour, sched_on_minute);
        else if (pick < 12)
            send_item(MODE_SECOND, sched_off_hour, sched_off_minute);
        else if (pick < 22)
            send_item(MODE_SECOND, h, mi);
        else if (pick < 50)
            send_item(MODE_MUX, h, mi);
        else if (pick < 97)
            send_item(MODE_MS, h, mi);
        else
            send_item(MODE_NONE, h, mi);
    endtask

    // Held lines after reset, the unused mode, and a full scan of 23:45.
    task automatic test_reset_state();
        send_item(MODE_MS, 5'd0, 6'd0);
        send_item(MODE_NONE, 5'd31, 6'd63);
        repeat (NUM_GRIDS) send_item(MODE_MUX, 5'd0, 6'd0);
        // Reset schedule has on time equal to off time, so nothing switches.
        send_item(MODE_SECOND, 5'd0, 6'd0);
        send_item(MODE_MUX, 5'd31, 6'd63);
    endtask

    // Hours and minutes beyond their normal range still split into digits.
    task automatic test_field_extremes();
        send_item(MODE_SECOND, 5'd31, 6'd63);
        repeat (NUM_GRIDS) send_item(MODE_MUX, 5'd0, 6'd0);
        send_item(MODE_SECOND, 5'd23, 6'd59);
        send_item(MODE_MUX, 5'd31, 6'd63);
    endtask

    // Filament switching at the on and off times, and a disabled schedule.
    task automatic test_schedule();
        load_config(5'd6, 6'd30, 5'd22, 6'd15, 10'd500);
        send_item(MODE_SECOND, 5'd22, 6'd15);
        send_item(MODE_SECOND, 5'd22, 6'd14);
        send_item(MODE_SECOND, 5'd6, 6'd30);
        send_item(MODE_SECOND, 5'd6, 6'd31);
        load_config(5'd23, 6'd59, 5'd0, 6'd0, 10'd1023);
        send_item(MODE_SECOND, 5'd0, 6'd0);
        send_item(MODE_SECOND, 5'd23, 6'd59);
        send_item(MODE_SECOND, 5'd0, 6'd0);
        // With the filament off, equal times must not turn it back on.
        load_config(5'd7, 6'd0, 5'd7, 6'd0, 10'd500);
        send_item(MODE_SECOND, 5'd7, 6'd0);
    endtask

    // Colon lit while the elapsed time is within the window, blank after.
    task automatic test_colon_window();
        load_config(5'd0, 6'd0, 5'd0, 6'd0, 10'd0);
        send_item(MODE_SECOND, 5'd12, 6'd34);
        show_colon_digit();
        send_item(MODE_MS, 5'd0, 6'd0);
        show_colon_digit();
        load_config(5'd0, 6'd0, 5'd0, 6'd0, 10'd1);
        send_item(MODE_SECOND, 5'd9, 6'd5);
        send_item(MODE_MS, 5'd0, 6'd0);
        show_colon_digit();
        send_item(MODE_MS, 5'd0, 6'd0);
        show_colon_digit();
    endtask

    // Run the timer into saturation, then widen the window to its maximum.
    task automatic test_timer_saturation();
        int ticks_needed;
        ticks_needed = (1 << ELAPSED_W) + 16;
        load_config(5'd0, 6'd0, 5'd0, 6'd0, 10'd1022);
        send_item(MODE_SECOND, 5'd18, 6'd0);
        for (int i = 0; i < ticks_needed; i++)
        begin
            if (i % 97 == 96)
                send_item(MODE_MUX, 5'($urandom), 6'($urandom));
            else
                send_item(MODE_MS, 5'($urandom), 6'($urandom));
        end
        show_colon_digit();
        load_config(5'd0, 6'd0, 5'd0, 6'd0, 10'd1023);
        send_item(MODE_MS, 5'd0, 6'd0);
        show_colon_digit();
    endtask

    // Receiver holds off while items keep coming, then the sender waits it out.
    task automatic test_backpressure();
        bit saved_idle;
        saved_idle = idle_on;
        idle_on    = 1'b0;
        hold_req   = 1'b1;
        repeat (40) send_random_item();
        drain_results();
        idle_on = saved_idle;
    endtask

    // Random traffic under extreme and random register settings.
    task automatic test_random_traffic();
        load_config(5'd0, 6'd0, 5'd0, 6'd0, 10'd0);
        repeat (PHASE_ITEMS) send_random_item();
        load_config(5'd23, 6'd59, 5'd23, 6'd59, 10'd1023);
        repeat (PHASE_ITEMS) send_random_item();
        load_config(5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                    5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)), 10'd2);
        repeat (PHASE_ITEMS) send_random_item();
        load_config(5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                    5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                    10'($urandom_range(0, 6)));
        repeat (PHASE_ITEMS) send_random_item();
        // Final stretch runs with neither side idling.
        load_config(5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                    5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)), 10'd3);
        idle_on = 1'b0;
        repeat (PHASE_ITEMS) send_random_item();
    endtask

    // Output side: check each transfer, then choose next cycle's ready.
    always @(posedge clk)
    begin : receive_side
        lines_t want;
        if (out_valid && out_ready)
        begin
            if (pending_lines.size() == 0)
            begin
                errors++;
                $display("%0t unexpected transfer: grid %h seg %h fil %b", $time,
                         grid_lines, segment_lines, filament_enable);
            end
            else
            begin
                want = pending_lines.pop_front();
                if (grid_lines !== want.grid)
                begin
                    errors++;
                    $display("%0t grid_lines mismatch: expected %h, actual %h", $time,
                             want.grid, grid_lines);
                end
                if (segment_lines !== want.seg)
                begin
                    errors++;
                    $display("%0t segment_lines mismatch: expected %h, actual %h", $time,
                             want.seg, segment_lines);
                end
                if (filament_enable !== want.fil)
                begin
                    errors++;
                    $display("%0t filament_enable mismatch: expected %b, actual %b", $time,
                             want.fil, filament_enable);
                end
            end
        end

        if (hold_req)
        begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("FAIL mirrored_vfd_clock_mux_driver");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        reset_display_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_field_extremes();
        test_schedule();
        test_colon_window();
        test_timer_saturation();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_lines.size() == 0)
            $display("PASS mirrored_vfd_clock_mux_driver");
        else
            $display("FAIL mirrored_vfd_clock_mux_driver");
        $finish;
    end

endmodule
